// ===== src/ekm_pkg.sv =====
`default_nettype none
package ekm_pkg;

  localparam int ENCODER_COUNT = 19;
  localparam int BUTTON_COUNT  = 26;
  localparam int COLUMN_COUNT  = 8;
  localparam int FRAME_W       = 8 * COLUMN_COUNT;

  localparam int SLOT_COUNT = ENCODER_COUNT + BUTTON_COUNT + 1;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int ENC_IW     = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
  localparam int BTN_IW     = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_CTRL     = 2'd2;
  localparam logic [1:0] KIND_FRAME    = 2'd3;

  localparam logic [5:0] LAYER0_BUTTON = 6'd20;
  localparam logic [5:0] LAYER1_BUTTON = 6'd22;
  localparam logic [5:0] LAYER2_BUTTON = 6'd24;
  localparam logic [5:0] CTRL_STRIDE   = 6'd20;

  localparam logic [1:0] LAYER_0 = 2'd0;
  localparam logic [1:0] LAYER_1 = 2'd1;
  localparam logic [1:0] LAYER_2 = 2'd2;

  localparam logic [5:0] BTN_POS [26] = '{
    6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63,
    6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd46, 6'd44, 6'd47, 6'd45,
    6'd38, 6'd39
  };

  typedef struct packed {
    logic              legal;
    logic signed [1:0] step;
  } step_t;

  typedef struct packed {
    logic              fire;
    logic signed [1:0] value;
  } enc_ev_t;

  function automatic step_t step_lookup(input logic [3:0] idx);
    step_t r;
    r.legal = 1'b1;
    r.step  = 2'sd0;
    unique case (idx)
      4'd0, 4'd5, 4'd10, 4'd15: r.step = 2'sd0;
      4'd1, 4'd7, 4'd8, 4'd14:  r.step = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: r.step = -2'sd1;
      default: r.legal = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/ekm_ifs.sv =====
`default_nettype none
interface ekm_in_if;
  import ekm_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] scan_frame;
  modport source (output valid, output scan_frame, input ready);
  modport sink (input valid, input scan_frame, output ready);
endinterface

interface ekm_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [5:0]        event_number;
  logic signed [1:0] event_value;
  logic [1:0]        layer_now;
  logic              last_of_frame;
  modport source (output valid, output event_kind, output event_number,
                  output event_value, output layer_now, output last_of_frame,
                  input ready);
  modport sink (input valid, input event_kind, input event_number,
                input event_value, input layer_now, input last_of_frame,
                output ready);
endinterface
`default_nettype wire

// ===== src/ekm_enc_lane.sv =====
`default_nettype none
module ekm_enc_lane (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic [1:0]      prv_pair,
  input  wire logic [1:0]      cur_pair,
  output ekm_pkg::enc_ev_t     ev
);
  import ekm_pkg::*;

  logic signed [3:0] count_r, count_nxt;
  logic signed [1:0] last_dir_r, last_dir_nxt;
  enc_ev_t           ev_r, ev_nxt;
  step_t             st;
  logic signed [1:0] s_eff;
  logic signed [3:0] sum;
  logic              fire;

  always_comb begin
    st           = step_lookup({prv_pair, cur_pair});
    s_eff        = st.legal ? st.step : last_dir_r;
    last_dir_nxt = st.legal ? st.step : last_dir_r;
    sum          = count_r + 4'(s_eff);
    fire         = (sum == 4'sd4) || (sum == -4'sd4);
    count_nxt    = fire ? 4'sd0 : sum;
    ev_nxt.fire  = fire;
    ev_nxt.value = sum[3] ? -2'sd1 : 2'sd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= 4'sd0;
      last_dir_r <= 2'sd0;
      ev_r       <= '0;
    end else if (load) begin
      count_r    <= count_nxt;
      last_dir_r <= last_dir_nxt;
      ev_r       <= ev_nxt;
    end
  end

  assign ev = ev_r;

endmodule
`default_nettype wire

// ===== src/ekm_merge.sv =====
`default_nettype none
module ekm_merge (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire ekm_pkg::enc_ev_t                enc_ev [ekm_pkg::ENCODER_COUNT],
  input  wire logic [ekm_pkg::BUTTON_COUNT-1:0] btn_chg,
  input  wire logic [ekm_pkg::BUTTON_COUNT-1:0] btn_cur,
  output logic                                 busy,
  ekm_out_if.source                            out_ch
);
  import ekm_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic [1:0]              layer_r, layer_nxt;
  logic [BUTTON_COUNT-1:0] chg_r, cur_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              kind_r;
  logic [5:0]              num_r;
  logic signed [1:0]       val_r;
  logic [1:0]              lay_r;
  logic                    last_r;

  logic              emit, advance, room;
  logic [1:0]        kind;
  logic [5:0]        num;
  logic signed [1:0] val;
  logic              last;
  logic [SLOT_W-1:0] boff;
  logic [BTN_IW-1:0] bidx;
  logic [5:0]        bnum;

  always_comb begin
    emit      = 1'b0;
    kind      = KIND_FRAME;
    num       = 6'd0;
    val       = 2'sd0;
    last      = 1'b0;
    layer_nxt = layer_r;
    busy_nxt  = busy_r;
    boff      = idx_r - SLOT_W'(ENCODER_COUNT);
    bidx      = boff[BTN_IW-1:0];
    bnum      = 6'(boff) + 6'd1;
    if (idx_r < SLOT_W'(ENCODER_COUNT)) begin
      emit = enc_ev[idx_r[ENC_IW-1:0]].fire;
      kind = KIND_CTRL;
      num  = 6'(idx_r) + 6'd1 + 6'(layer_r) * CTRL_STRIDE;
      val  = enc_ev[idx_r[ENC_IW-1:0]].value;
    end else if (idx_r < SLOT_W'(ENCODER_COUNT + BUTTON_COUNT)) begin
      if (chg_r[bidx]) begin
        priority if (bnum == LAYER0_BUTTON) begin
          layer_nxt = LAYER_0;
        end else if (bnum == LAYER1_BUTTON) begin
          layer_nxt = LAYER_1;
        end else if (bnum == LAYER2_BUTTON) begin
          layer_nxt = LAYER_2;
        end else begin
          emit = 1'b1;
          kind = cur_r[bidx] ? KIND_NOTE_ON : KIND_NOTE_OFF;
          num  = bnum;
        end
      end
    end else begin
      emit     = 1'b1;
      last     = 1'b1;
      busy_nxt = 1'b0;
    end
  end

  assign room          = !out_valid_r || out_ch.ready;
  assign advance       = busy_r && (room || !emit);
  assign idx_nxt       = idx_r + SLOT_W'(1);
  assign out_valid_nxt = (advance && emit) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      layer_r     <= LAYER_0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (advance) begin
        busy_r  <= busy_nxt;
        idx_r   <= idx_nxt;
        layer_r <= layer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      chg_r <= btn_chg;
      cur_r <= btn_cur;
    end
    if (advance && emit) begin
      kind_r <= kind;
      num_r  <= num;
      val_r  <= val;
      lay_r  <= layer_nxt;
      last_r <= last;
    end
  end

  assign busy                 = busy_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = kind_r;
  assign out_ch.event_number  = num_r;
  assign out_ch.event_value   = val_r;
  assign out_ch.layer_now     = lay_r;
  assign out_ch.last_of_frame = last_r;

endmodule
`default_nettype wire

// ===== src/encoder_key_matrix_event_engine.sv =====
`default_nettype none
// Takes one scanned key matrix frame per input word and emits the events it
// causes against the previous frame: control changes for the encoders, note-on
// and note-off for the buttons, layer switches on buttons 20, 22 and 24, and a
// closing frame-end word. All encoder lanes and all button change detectors
// evaluate a frame in the cycle it is accepted; the merge sequencer then visits
// one slot per cycle, 46 slots in all, while a slot that emits waits as long
// as the output register is full and stalled. The next frame is accepted as
// soon as the frame-end word has been loaded into the output register.
module encoder_key_matrix_event_engine (
  input wire logic  clk,
  input wire logic  rst_n,
  ekm_in_if.sink    in_ch,
  ekm_out_if.source out_ch
);
  import ekm_pkg::*;

  logic [FRAME_W-1:0]      prev_frame_r;
  logic                    accept, busy;
  enc_ev_t                 enc_ev [ENCODER_COUNT];
  logic [BUTTON_COUNT-1:0] btn_chg, btn_cur;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_frame_r <= '0;
    end else if (accept) begin
      prev_frame_r <= in_ch.scan_frame;
    end
  end

  for (genvar e = 0; e < ENCODER_COUNT; e++) begin : g_enc
    ekm_enc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (accept),
      .prv_pair (prev_frame_r[2*e +: 2]),
      .cur_pair (in_ch.scan_frame[2*e +: 2]),
      .ev       (enc_ev[e])
    );
  end

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
    assign btn_cur[b] = in_ch.scan_frame[BTN_POS[b]];
    assign btn_chg[b] = in_ch.scan_frame[BTN_POS[b]] ^ prev_frame_r[BTN_POS[b]];
  end

  ekm_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .enc_ev  (enc_ev),
    .btn_chg (btn_chg),
    .btn_cur (btn_cur),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== verif/encoder_key_matrix_event_engine_tb.sv =====
`default_nettype none
module encoder_key_matrix_event_engine_tb;
  import ekm_pkg::*;

  typedef struct {
    logic [1:0]        kind;
    logic [5:0]        number;
    logic signed [1:0] value;
    logic [1:0]        layer;
    logic              last;
  } midi_event_t;

  typedef struct packed {
    logic [63:0] frame;
    logic        known;
    logic [1:0]  layer;
  } script_row_t;

  localparam int NO_STEP      = 2;
  localparam int SCRIPT_ROWS  = 24;
  localparam int RANDOM_SCANS = 246;
  localparam int DRAIN_SCAN   = 150;

  // Step per (previous pair, current pair); NO_STEP marks a jump of two phases.
  localparam int QUAD_STEP [16] = '{
    0, 1, -1, NO_STEP,
    -1, 0, NO_STEP, 1,
    1, NO_STEP, 0, -1,
    NO_STEP, -1, 1, 0
  };

  // The Gray order is its own inverse, so one table maps phase to pair and back.
  localparam logic [1:0] QUAD_ORDER [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, LAYER_0},
    '{64'h0000_003F_FFFF_FFFF, 1'b1, LAYER_0},
    '{64'h0000_0000_0000_0000, 1'b1, LAYER_0},
    '{64'h0000_0015_5555_5555, 1'b0, LAYER_0},
    '{64'h0000_003F_FFFF_FFFF, 1'b0, LAYER_0},
    '{64'h0000_002A_AAAA_AAAA, 1'b0, LAYER_0},
    '{64'h0000_0000_0000_0000, 1'b0, LAYER_0},
    '{64'h0000_1000_0000_0000, 1'b0, LAYER_0},
    '{64'h0000_1000_0000_0000, 1'b1, LAYER_1},
    '{64'h0000_102A_AAAA_AAAA, 1'b0, LAYER_0},
    '{64'h0000_103F_FFFF_FFFF, 1'b0, LAYER_0},
    '{64'h0000_1015_5555_5555, 1'b0, LAYER_0},
    '{64'h0000_1000_0000_0000, 1'b0, LAYER_0},
    '{64'h0000_3000_0000_0000, 1'b0, LAYER_0},
    '{64'h0000_3015_5555_5555, 1'b0, LAYER_0},
    '{64'h0000_303F_FFFF_FFFF, 1'b0, LAYER_0},
    '{64'h0000_302A_AAAA_AAAA, 1'b0, LAYER_0},
    '{64'h0000_3000_0000_0000, 1'b0, LAYER_0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, LAYER_0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, LAYER_0},
    '{64'h0000_0000_0000_0000, 1'b0, LAYER_0},
    '{64'h0000_0000_0000_0000, 1'b1, LAYER_2},
    '{64'h8000_0000_0000_0001, 1'b0, LAYER_0},
    '{64'h0000_0000_0000_0000, 1'b0, LAYER_0}
  };

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatch_count;

  logic [63:0] prev_scan;
  int          turn_count [ENCODER_COUNT];
  int          last_dir [ENCODER_COUNT];
  logic [1:0]  cur_layer;
  midi_event_t frame_events[$];
  midi_event_t pending_events[$];

  ekm_in_if  in_if ();
  ekm_out_if out_if ();

  encoder_key_matrix_event_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 15);
    if (r < 11) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(30, 120);
  endfunction

  function automatic midi_event_t make_event(input logic [1:0] kind, input int number,
                                             input int value, input logic [1:0] layer,
                                             input logic last);
    midi_event_t ev;
    ev.kind   = kind;
    ev.number = number[5:0];
    ev.value  = value[1:0];
    ev.layer  = layer;
    ev.last   = last;
    return ev;
  endfunction

  task automatic predict_frame(input logic [63:0] f);
    int s;
    int num;
    logic [1:0] p;
    logic [1:0] c;
    frame_events.delete();
    for (int e = 0; e < ENCODER_COUNT; e++) begin
      p = prev_scan[2*e +: 2];
      c = f[2*e +: 2];
      s = QUAD_STEP[{p, c}];
      if (s == NO_STEP) begin
        s = last_dir[e];
      end else begin
        last_dir[e] = s;
      end
      turn_count[e] += s;
      if (turn_count[e] >= 4 || turn_count[e] <= -4) begin
        num = e + 1 + int'(CTRL_STRIDE) * int'(cur_layer);
        frame_events.push_back(make_event(KIND_CTRL, num, turn_count[e] / 4, cur_layer, 1'b0));
        turn_count[e] = 0;
      end
    end
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (prev_scan[BTN_POS[b]] != f[BTN_POS[b]]) begin
        num = b + 1;
        if (num == LAYER0_BUTTON) begin
          cur_layer = LAYER_0;
        end else if (num == LAYER1_BUTTON) begin
          cur_layer = LAYER_1;
        end else if (num == LAYER2_BUTTON) begin
          cur_layer = LAYER_2;
        end else begin
          frame_events.push_back(make_event(f[BTN_POS[b]] ? KIND_NOTE_ON : KIND_NOTE_OFF,
                                            num, 0, cur_layer, 1'b0));
        end
      end
    end
    frame_events.push_back(make_event(KIND_FRAME, 0, 0, cur_layer, 1'b1));
    prev_scan = f;
  endtask

  // A row with a known result expects the frame-end word alone, at the given layer.
  task automatic send_scan(input logic [63:0] f, input logic known, input logic [1:0] layer,
                           input bit drain_first);
    int gap;
    if (!calm && $urandom_range(0, 2) == 0) gap = idle_length();
    else gap = 0;
    if (drain_first && gap == 0) gap = 1;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain_first) begin
        while (pending_events.size() != 0) @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.scan_frame <= f;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_frame(f);
    if (known) begin
      pending_events.push_back(make_event(KIND_FRAME, 0, 0, layer, 1'b1));
    end else begin
      foreach (frame_events[i]) pending_events.push_back(frame_events[i]);
    end
  endtask

  task automatic check_field(input string field, input integer want, input integer got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if (!calm && $urandom_range(0, 4) == 0) hold = idle_length();
      out_if.ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin
    midi_event_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected word: no event pending");
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_if.event_kind);
        check_field("event_number", want.number, out_if.event_number);
        check_field("event_value", want.value, out_if.event_value);
        check_field("layer_now", want.layer, out_if.layer_now);
        check_field("last_of_frame", want.last, out_if.last_of_frame);
      end
    end
  end

  initial begin
    logic [63:0] scan_now;
    logic [63:0] frame;
    logic [1:0]  ph;
    bit          enc_up [ENCODER_COUNT];
    int          r;

    mismatch_count = 0;
    calm = 1'b0;
    prev_scan = '0;
    cur_layer = LAYER_0;
    foreach (turn_count[e]) begin
      turn_count[e] = 0;
      last_dir[e] = 0;
      enc_up[e] = $urandom_range(0, 1);
    end
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.scan_frame <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < SCRIPT_ROWS; n++) begin
      calm = (n >= 3 && n <= 12);
      send_scan(SCRIPT[n].frame, SCRIPT[n].known, SCRIPT[n].layer, 1'b0);
    end
    scan_now = SCRIPT[SCRIPT_ROWS-1].frame;

    // Mostly encoders turning in Gray order with a few buttons toggling; some
    // frames jump two phases, and some are pure noise.
    for (int n = 0; n < RANDOM_SCANS; n++) begin
      calm = (n >= 80 && n < 120);
      if ($urandom_range(0, 6) == 0) begin
        frame = {$urandom, $urandom};
      end else begin
        frame = scan_now;
        for (int e = 0; e < ENCODER_COUNT; e++) begin
          r = $urandom_range(0, 19);
          if (r < 2) enc_up[e] = !enc_up[e];
          ph = QUAD_ORDER[frame[2*e +: 2]];
          if (r < 10) begin
            ph = enc_up[e] ? ph + 2'd1 : ph - 2'd1;
            frame[2*e +: 2] = QUAD_ORDER[ph];
          end else if (r < 13) begin
            ph = enc_up[e] ? ph - 2'd1 : ph + 2'd1;
            frame[2*e +: 2] = QUAD_ORDER[ph];
          end else if (r == 19) begin
            frame[2*e +: 2] = frame[2*e +: 2] ^ 2'b11;
          end
        end
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if ($urandom_range(0, 9) == 0) frame[BTN_POS[b]] = !frame[BTN_POS[b]];
        end
      end
      send_scan(frame, 1'b0, LAYER_0, n == DRAIN_SCAN);
      scan_now = frame;
    end

    in_if.valid <= 1'b0;
    calm = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
